### hdl/random_connected_graph_builder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the random connected graph builder.
// They expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RANDOM_CONNECTED_GRAPH_BUILDER_ASSERT_SVH
`define RANDOM_CONNECTED_GRAPH_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RCG_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rcg assertion failed");
// next-cycle implication
`define RCG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rcg assertion failed");
`else
`define RCG_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RCG_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### hdl/rcg_pkg.sv
// ---------------------------------------------------------------------------
// rcg_pkg
// Shared types and constants of the random connected graph builder.
// ---------------------------------------------------------------------------
`default_nettype none

package rcg_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int CNT_W     = 7;
    localparam int EDGE_W    = 11;
    localparam int ROW_W     = MAX_NODES;
    localparam int PROD_W    = 2 * CNT_W;
    localparam int CFG_IDX_W = 1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TARGET = 1'b1;

    localparam logic [CNT_W-1:0]  NODE_COUNT_RST  = 7'd8;
    localparam logic [EDGE_W-1:0] EDGE_TARGET_RST = 11'd8;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_TARGET = 2'd1,
        ST_RANGE      = 2'd2,
        ST_NOT_RUN    = 2'd3
    } status_t;

    typedef struct packed {
        logic              command;
        logic [NODE_W-1:0] draw;
    } item_t;

    typedef struct packed {
        logic              edge_valid;
        logic [NODE_W-1:0] low_node;
        logic [NODE_W-1:0] high_node;
        logic              finished;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

### hdl/rcg_adj_ram.sv
// ---------------------------------------------------------------------------
// rcg_adj_ram
// Adjacency row store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rcg_adj_ram
    import rcg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [NODE_W-1:0] rd_addr,
    output logic      [ROW_W-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [NODE_W-1:0] wr_addr,
    input  wire logic [ROW_W-1:0]  wr_data
);

    logic [ROW_W-1:0] mem [MAX_NODES];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/rcg_core.sv
// ---------------------------------------------------------------------------
// rcg_core
// Lookup stage: walk/pair state, visited flags, adjacency read-modify-write.
// ---------------------------------------------------------------------------
`default_nettype none

module rcg_core
    import rcg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire item_t             in_item,
    input  wire logic              out_free,
    input  wire logic [CNT_W-1:0]  node_count,
    input  wire logic [EDGE_W-1:0] edge_target,
    output logic                   busy,
    output logic                   res_push,
    output result_t                res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIRST,
        PH_WALK,
        PH_PAIRS,
        PH_DONE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [ROW_W-1:0]    visited_reg, visited_next;
    logic [ROW_W-1:0]    row_valid_reg, row_valid_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [NODE_W-1:0]   walk_reg, walk_next;
    logic [NODE_W-1:0]   pf_reg, pf_next;
    logic                pending_reg, pending_next;
    logic [EDGE_W-1:0]   edges_reg, edges_next;
    logic [CNT_W-1:0]    run_nodes_reg, run_nodes_next;
    logic [EDGE_W-1:0]   run_target_reg, run_target_next;

    // request held in the lookup stage
    logic                s1_valid_reg;
    item_t               s1_item_reg;
    logic [NODE_W-1:0]   s1_row_reg;
    logic                s1_rv_reg, s1_rv_next;
    logic                s1_fwd_reg;

    // last row written, for the write that lands on the read edge
    logic [NODE_W-1:0]   lw_addr_reg;
    logic [ROW_W-1:0]    lw_data_reg;

    logic                commit;
    logic                start_commit;
    logic [NODE_W-1:0]   d;
    logic [NODE_W-1:0]   from;
    logic [NODE_W-1:0]   lo;
    logic [NODE_W-1:0]   hi;
    logic [ROW_W-1:0]    ram_q;
    logic [ROW_W-1:0]    row_cur;
    logic [ROW_W-1:0]    row_set;
    logic                make_edge;
    logic                wr_en;
    logic [PROD_W-1:0]   max_edges;
    logic                bad_target;
    logic [NODE_W-1:0]   rd_from;
    logic [NODE_W-1:0]   rd_addr;

    assign commit       = s1_valid_reg & out_free;
    assign start_commit = commit & (s1_item_reg.command == CMD_START);
    assign busy         = s1_valid_reg;
    assign res_push     = commit;

    assign d       = s1_item_reg.draw;
    assign from    = (phase_reg == PH_WALK) ? walk_reg : pf_reg;
    assign lo      = (from < d) ? from : d;
    assign hi      = (from < d) ? d : from;
    assign row_cur = (s1_fwd_reg && (lw_addr_reg == s1_row_reg)) ? lw_data_reg :
                     (s1_rv_reg ? ram_q : '0);
    assign row_set = row_cur | (ROW_W'(1) << hi);

    assign max_edges  = (PROD_W'(node_count) * PROD_W'(node_count - CNT_W'(1))) >> 1;
    assign bad_target = (node_count < CNT_W'(2)) || (node_count > CNT_W'(MAX_NODES)) ||
                        (edge_target < EDGE_W'(node_count)) ||
                        (PROD_W'(edge_target) > max_edges);

    always_comb begin
        phase_next      = phase_reg;
        visited_next    = visited_reg;
        row_valid_next  = row_valid_reg;
        total_next      = total_reg;
        walk_next       = walk_reg;
        pf_next         = pf_reg;
        pending_next    = pending_reg;
        edges_next      = edges_reg;
        run_nodes_next  = run_nodes_reg;
        run_target_next = run_target_reg;
        make_edge       = 1'b0;
        wr_en           = 1'b0;
        res             = '0;
        res.status      = ST_OK;
        if (commit) begin
            if (s1_item_reg.command == CMD_START) begin
                visited_next   = '0;
                row_valid_next = '0;
                total_next     = '0;
                walk_next      = '0;
                pf_next        = '0;
                pending_next   = 1'b0;
                edges_next     = '0;
                if (bad_target) begin
                    phase_next      = PH_IDLE;
                    run_nodes_next  = '0;
                    run_target_next = '0;
                    res.status      = ST_BAD_TARGET;
                end else begin
                    phase_next      = PH_FIRST;
                    run_nodes_next  = node_count;
                    run_target_next = edge_target;
                end
            end else if (phase_reg == PH_IDLE || phase_reg == PH_DONE) begin
                res.status = ST_NOT_RUN;
            end else if (CNT_W'(d) >= run_nodes_reg) begin
                res.status = ST_RANGE;
            end else begin
                unique case (phase_reg)
                    PH_FIRST: begin
                        visited_next[d] = 1'b1;
                        total_next      = CNT_W'(1);
                        walk_next       = d;
                        phase_next      = PH_WALK;
                    end
                    PH_WALK: begin
                        walk_next = d;
                        if (!visited_reg[d]) begin
                            visited_next[d] = 1'b1;
                            total_next      = total_reg + CNT_W'(1);
                            make_edge       = 1'b1;
                            if (total_next >= run_nodes_reg) begin
                                phase_next = PH_PAIRS;
                            end
                        end
                    end
                    PH_PAIRS: begin
                        if (!pending_reg) begin
                            pf_next      = d;
                            pending_next = 1'b1;
                        end else begin
                            pending_next = 1'b0;
                            // self-loops and known edges are dropped
                            make_edge = (pf_reg != d) && !row_cur[hi];
                        end
                    end
                    default: begin
                    end
                endcase
                if (make_edge) begin
                    wr_en              = 1'b1;
                    row_valid_next[lo] = 1'b1;
                    edges_next         = edges_reg + EDGE_W'(1);
                    res.edge_valid     = 1'b1;
                    res.low_node       = lo;
                    res.high_node      = hi;
                    if (edges_next >= run_target_reg) begin
                        res.finished = 1'b1;
                        phase_next   = PH_DONE;
                    end
                end
            end
        end
    end

    // row for the incoming request follows the state this commit leaves
    assign rd_from    = (phase_next == PH_WALK) ? walk_next : pf_next;
    assign rd_addr    = (rd_from < in_item.draw) ? rd_from : in_item.draw;
    assign s1_rv_next = row_valid_reg[rd_addr] & ~start_commit;

    rcg_adj_ram u_adj_ram (
        .aclk    (aclk),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (ram_q),
        .wr_en   (wr_en),
        .wr_addr (lo),
        .wr_data (row_set)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            visited_reg    <= '0;
            row_valid_reg  <= '0;
            total_reg      <= '0;
            walk_reg       <= '0;
            pf_reg         <= '0;
            pending_reg    <= 1'b0;
            edges_reg      <= '0;
            run_nodes_reg  <= '0;
            run_target_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s1_rv_reg      <= 1'b0;
            s1_fwd_reg     <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            visited_reg    <= visited_next;
            row_valid_reg  <= row_valid_next;
            total_reg      <= total_next;
            walk_reg       <= walk_next;
            pf_reg         <= pf_next;
            pending_reg    <= pending_next;
            edges_reg      <= edges_next;
            run_nodes_reg  <= run_nodes_next;
            run_target_reg <= run_target_next;
            if (in_accept) begin
                s1_valid_reg <= 1'b1;
                s1_rv_reg    <= s1_rv_next;
                s1_fwd_reg   <= wr_en;
            end else if (commit) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_item_reg <= in_item;
            s1_row_reg  <= rd_addr;
        end
        if (wr_en) begin
            lw_addr_reg <= lo;
            lw_data_reg <= row_set;
        end
    end

endmodule

`default_nettype wire

### hdl/random_connected_graph_builder.sv
// ---------------------------------------------------------------------------
// random_connected_graph_builder
// Random spanning walk over the nodes, then random extra edges up to a target.
//
//   channel   dir   handshake            payload
//   s_*       in    s_valid / s_ready    s_command, s_draw
//   m_*       out   m_valid / m_ready    m_edge_valid, m_low_node, m_high_node,
//                                        m_finished, m_status
//   cfg_*     in    cfg_wr_en            cfg_index, cfg_wdata
//
// One request per cycle sustained while the output is not stalled. A request
// passes the lookup stage (adjacency RAM read), then the output register.
// A start request clears visited flags and adjacency row-valid flops at once;
// no clearing pass after reset.
// A stalled output holds the lookup stage; s_ready drops only when both are
// full and m_ready is low.
// ---------------------------------------------------------------------------
`default_nettype none
`include "random_connected_graph_builder_assert.svh"

module random_connected_graph_builder
    import rcg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_command,
    input  wire logic [NODE_W-1:0]    s_draw,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_edge_valid,
    output logic      [NODE_W-1:0]    m_low_node,
    output logic      [NODE_W-1:0]    m_high_node,
    output logic                      m_finished,
    output logic      [1:0]           m_status,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [EDGE_W-1:0]    cfg_wdata
);

    logic [CNT_W-1:0]  node_count_reg;
    logic [EDGE_W-1:0] edge_target_reg;
    logic              m_valid_reg;
    result_t           m_res_reg;
    logic              out_free;
    logic              in_accept;
    logic              busy;
    logic              res_push;
    item_t             in_item;
    result_t           res;
    logic              res_blank;
    logic              edge_sane;

    assign out_free  = ~m_valid_reg | m_ready;
    assign s_ready   = ~busy | out_free;
    assign in_accept = s_valid & s_ready;

    assign in_item.command = s_command;
    assign in_item.draw    = s_draw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg  <= NODE_COUNT_RST;
            edge_target_reg <= EDGE_TARGET_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NODE_COUNT:  node_count_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_EDGE_TARGET: edge_target_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rcg_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_item     (in_item),
        .out_free    (out_free),
        .node_count  (node_count_reg),
        .edge_target (edge_target_reg),
        .busy        (busy),
        .res_push    (res_push),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_edge_valid = m_res_reg.edge_valid;
    assign m_low_node   = m_res_reg.low_node;
    assign m_high_node  = m_res_reg.high_node;
    assign m_finished   = m_res_reg.finished;
    assign m_status     = m_res_reg.status;

    assign res_blank = (m_low_node == '0) && (m_high_node == '0) && !m_finished;
    assign edge_sane = (m_low_node < m_high_node) && (m_status == ST_OK);

    `RCG_ASSERT_NEXT(a_accept_loads_stage, aclk, aresetn, in_accept, busy)
    `RCG_ASSERT_IMPL(a_no_edge_zero, aclk, aresetn, m_valid && !m_edge_valid, res_blank)
    `RCG_ASSERT_IMPL(a_edge_ordered, aclk, aresetn, m_valid && m_edge_valid, edge_sane)
    `RCG_ASSERT_NEXT(a_stall_holds_stage, aclk, aresetn, busy && !out_free, busy && m_valid)

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: random connected graph builder
// Drives start and node-draw requests through the input channel, predicts each
// result with a local graph-walk tracker and checks every output field.
// Coverage: rejected starts, walk, pair phase, finished graphs and idle draws.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rcg_pkg::*;

    typedef enum logic [2:0] {
        BLD_IDLE,
        BLD_FIRST,
        BLD_WALK,
        BLD_PAIRS,
        BLD_DONE
    } build_phase_t;

    localparam int RANDOM_REQUESTS = 1400;
    localparam int MAX_REPORTS     = 20;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_command = CMD_START;
    logic [NODE_W-1:0]    s_draw    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_edge_valid;
    logic [NODE_W-1:0]    m_low_node;
    logic [NODE_W-1:0]    m_high_node;
    logic                 m_finished;
    logic [1:0]           m_status;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_NODE_COUNT;
    logic [EDGE_W-1:0]    cfg_wdata = '0;

    random_connected_graph_builder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_draw      (s_draw),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_edge_valid(m_edge_valid),
        .m_low_node  (m_low_node),
        .m_high_node (m_high_node),
        .m_finished  (m_finished),
        .m_status    (m_status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    // graph tracker state
    int unsigned          cfg_nodes     = NODE_COUNT_RST;
    int unsigned          cfg_target    = EDGE_TARGET_RST;
    build_phase_t         run_phase     = BLD_IDLE;
    int unsigned          run_nodes     = 0;
    int unsigned          run_target    = 0;
    logic [MAX_NODES-1:0] seen_mask     = '0;
    int unsigned          visited_total = 0;
    logic [NODE_W-1:0]    walk_node     = '0;
    logic [NODE_W-1:0]    pair_first    = '0;
    logic                 pair_pending  = 1'b0;
    logic [EDGE_W-1:0]    edges_made    = '0;
    logic [MAX_NODES-1:0] adjacency [MAX_NODES] = '{default: '0};

    item_t   requests_to_send [$];
    result_t results_due [$];
    item_t   next_req;
    result_t want;

    int unsigned pushed_total   = 0;
    int unsigned accepted_total = 0;
    int unsigned send_gap_pct   = 7;
    int unsigned recv_stall_pct = 67;
    int unsigned fault_count    = 0;
    int unsigned edges_seen     = 0;
    int unsigned graphs_done    = 0;
    int unsigned starts_refused = 0;
    int unsigned draws_range    = 0;
    int unsigned draws_idle     = 0;

    function automatic result_t link_nodes(input logic [NODE_W-1:0] na, nb);
        result_t r;
        r = '0;
        adjacency[na][nb] = 1'b1;
        adjacency[nb][na] = 1'b1;
        edges_made = edges_made + 1'b1;
        r.edge_valid = 1'b1;
        r.low_node   = (na < nb) ? na : nb;
        r.high_node  = (na < nb) ? nb : na;
        r.status     = ST_OK;
        if (edges_made >= run_target) begin
            r.finished = 1'b1;
            run_phase  = BLD_DONE;
        end
        return r;
    endfunction

    function automatic result_t graph_step(input item_t req);
        result_t           r;
        int unsigned       max_edges;
        logic [NODE_W-1:0] from_node;
        r = '0;
        r.status = ST_OK;
        if (req.command == CMD_START) begin
            max_edges     = cfg_nodes * (cfg_nodes - 1) / 2;
            seen_mask     = '0;
            foreach (adjacency[i]) adjacency[i] = '0;
            visited_total = 0;
            walk_node     = '0;
            edges_made    = '0;
            pair_first    = '0;
            pair_pending  = 1'b0;
            if (cfg_nodes < 2 || cfg_nodes > MAX_NODES ||
                    cfg_target < cfg_nodes || cfg_target > max_edges) begin
                run_phase  = BLD_IDLE;
                run_nodes  = 0;
                run_target = 0;
                r.status   = ST_BAD_TARGET;
            end else begin
                run_nodes  = cfg_nodes;
                run_target = cfg_target;
                run_phase  = BLD_FIRST;
            end
            return r;
        end
        if (run_phase == BLD_IDLE || run_phase == BLD_DONE) begin
            r.status = ST_NOT_RUN;
            return r;
        end
        if (req.draw >= run_nodes) begin
            // pending pair half survives a bad draw
            r.status = ST_RANGE;
            return r;
        end
        case (run_phase)
            BLD_FIRST: begin
                seen_mask[req.draw] = 1'b1;
                visited_total = 1;
                walk_node     = req.draw;
                run_phase     = BLD_WALK;
            end
            BLD_WALK: begin
                from_node = walk_node;
                walk_node = req.draw;
                if (!seen_mask[req.draw]) begin
                    seen_mask[req.draw] = 1'b1;
                    visited_total++;
                    r = link_nodes(from_node, req.draw);
                    if (run_phase == BLD_WALK && visited_total >= run_nodes)
                        run_phase = BLD_PAIRS;
                end
            end
            default: begin
                if (!pair_pending) begin
                    pair_first   = req.draw;
                    pair_pending = 1'b1;
                end else begin
                    pair_pending = 1'b0;
                    if (pair_first != req.draw && !adjacency[pair_first][req.draw])
                        r = link_nodes(pair_first, req.draw);
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string field,
                                        input logic [EDGE_W-1:0] exp_val, got_val);
        if (got_val !== exp_val) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("[%0t] %s mismatch: expected %0d, got %0d",
                         $time, field, exp_val, got_val);
        end
    endfunction

    initial begin
        forever #4 aclk = ~aclk;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                results_due.insert(results_due.size(), graph_step({s_command, s_draw}));
                accepted_total++;
            end
            if (!s_valid || s_ready) begin
                if (requests_to_send.size() != 0 &&
                        $urandom_range(99) >= send_gap_pct) begin
                    next_req = requests_to_send.pop_front();
                    s_valid   <= 1'b1;
                    s_command <= next_req.command;
                    s_draw    <= next_req.draw;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: expected none, got status %0d",
                             $time, m_status);
            end else begin
                want = results_due.pop_front();
                check_field("edge_valid", EDGE_W'(want.edge_valid), EDGE_W'(m_edge_valid));
                check_field("low_node",   EDGE_W'(want.low_node),   EDGE_W'(m_low_node));
                check_field("high_node",  EDGE_W'(want.high_node),  EDGE_W'(m_high_node));
                check_field("finished",   EDGE_W'(want.finished),   EDGE_W'(m_finished));
                check_field("status",     EDGE_W'(want.status),     EDGE_W'(m_status));
            end
            if (m_edge_valid) edges_seen++;
            if (m_finished) graphs_done++;
            case (m_status)
                ST_BAD_TARGET: starts_refused++;
                ST_RANGE:      draws_range++;
                ST_NOT_RUN:    draws_idle++;
                default: ;
            endcase
        end
    end

    task automatic push_req(input logic cmd, input int unsigned node);
        item_t req;
        req.command = cmd;
        req.draw    = NODE_W'(node);
        requests_to_send.insert(requests_to_send.size(), req);
        pushed_total++;
    endtask

    task automatic wait_drained();
        while (accepted_total != pushed_total || results_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // registers only change with nothing in flight
    task automatic start_with(input int unsigned nodes, target);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NODE_COUNT;
        cfg_wdata <= EDGE_W'(nodes);
        @(posedge aclk);
        cfg_index <= CFG_EDGE_TARGET;
        cfg_wdata <= EDGE_W'(target);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_nodes  = nodes & 32'h7F;
        cfg_target = target & 32'h7FF;
        push_req(CMD_START, $urandom_range(63));
    endtask

    // keeps feeding draws until the tracked graph completes or stops, or the guard runs out
    task automatic grow_graph(input int unsigned nodes);
        int unsigned guard;
        int unsigned pick;
        guard = 0;
        while (accepted_total != pushed_total) @(posedge aclk);
        while (run_phase != BLD_DONE && run_phase != BLD_IDLE && guard < 3000) begin
            while (pushed_total - accepted_total >= 4) @(posedge aclk);
            repeat (4) begin
                pick = $urandom_range(199);
                if (pick == 0 && nodes <= 10)
                    push_req(CMD_START, $urandom_range(63));
                else if (pick < 12 && nodes < MAX_NODES)
                    push_req(CMD_DRAW, $urandom_range(63, nodes));
                else
                    push_req(CMD_DRAW, $urandom_range(nodes - 1));
                guard++;
            end
        end
    endtask

    initial begin
        int unsigned directed_total;
        int unsigned n;
        int unsigned t;
        int unsigned mx;
        int unsigned pick;
        int unsigned done_rand;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle draw, default config, a full triangle, start bounds
        push_req(CMD_DRAW, 63);
        push_req(CMD_START, 0);
        start_with(3, 3);
        push_req(CMD_DRAW, 0);
        push_req(CMD_DRAW, 0);   // revisit, walk only
        push_req(CMD_DRAW, 3);   // out of range
        push_req(CMD_DRAW, 1);
        push_req(CMD_DRAW, 2);   // last node visited, pairs begin
        push_req(CMD_DRAW, 1);
        push_req(CMD_DRAW, 63);  // out of range with half a pair held
        push_req(CMD_DRAW, 1);   // self loop
        push_req(CMD_DRAW, 2);
        push_req(CMD_DRAW, 1);   // already adjacent
        push_req(CMD_DRAW, 0);
        push_req(CMD_DRAW, 2);   // completes the triangle
        push_req(CMD_DRAW, 0);   // after finish
        start_with(0, 0);
        start_with(127, 2047);
        start_with(65, 2016);
        start_with(64, 2016);
        push_req(CMD_DRAW, 63);
        push_req(CMD_DRAW, 62);
        push_req(CMD_DRAW, 0);
        start_with(64, 2017);
        start_with(64, 63);
        start_with(2, 2);
        directed_total = pushed_total;

        while (pushed_total - directed_total < RANDOM_REQUESTS) begin
            done_rand = pushed_total - directed_total;
            if (done_rand < RANDOM_REQUESTS / 3) begin
                send_gap_pct   = 7;
                recv_stall_pct = 67;
            end else if (done_rand < 2 * RANDOM_REQUESTS / 3) begin
                send_gap_pct   = 67;
                recv_stall_pct = 7;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                case ($urandom_range(3))
                    0: begin n = $urandom_range(2);        t = $urandom_range(2047); end
                    1: begin n = $urandom_range(127, 65);  t = $urandom_range(2047); end
                    2: begin n = $urandom_range(64, 3);    t = $urandom_range(n - 1); end
                    default: begin
                        n = $urandom_range(64, 3);
                        t = $urandom_range(2047, n * (n - 1) / 2 + 1);
                    end
                endcase
                start_with(n, t);
                push_req(CMD_DRAW, $urandom_range(63));
            end else begin
                if (pick < 10)
                    n = MAX_NODES;
                else if (pick < 16)
                    n = $urandom_range(32, 11);
                else
                    n = $urandom_range(10, 3);
                mx = n * (n - 1) / 2;
                if (n > 10)
                    t = $urandom_range(n + 8, n);
                else begin
                    case ($urandom_range(3))
                        0, 1: t = $urandom_range((n + 3 < mx) ? n + 3 : mx, n);
                        2:    t = mx;
                        default: t = $urandom_range(mx, n);
                    endcase
                end
                start_with(n, t);
                grow_graph(n);
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);

        $display("Covered %0d requests: %0d edges, %0d graphs completed.",
                 accepted_total, edges_seen, graphs_done);
        $display("Rejected starts %0d, out-of-range draws %0d, draws while stopped %0d.",
                 starts_refused, draws_range, draws_idle);
        if (fault_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results still due.", results_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### random_connected_graph_builder.f
+incdir+hdl
hdl/rcg_pkg.sv
hdl/rcg_adj_ram.sv
hdl/rcg_core.sv
hdl/random_connected_graph_builder.sv
sim/tb_top.sv
